/* src/bounded_fifo_with_stats_top_macros.svh */
// Assertion macros used by the FIFO datapath.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef BOUNDED_FIFO_WITH_STATS_TOP_MACROS_SVH
`define BOUNDED_FIFO_WITH_STATS_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bfws_pkg.sv */
// Shared types and constants of the bounded FIFO with statistics.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package bfws_pkg;

    localparam int DEPTH     = 1024;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int STAT_W    = 32;
    localparam int CFG_W     = 11;
    localparam int PDATA_W   = 32;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = CFG_W'(1024);

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_GET = 1'b1;

    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } t_in_req;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] read_word;
        logic [10:0]        fill_level;
        logic [31:0]        add_tries;
        logic [31:0]        get_tries;
        logic [31:0]        adds_done;
        logic [31:0]        gets_done;
    } t_out_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_op;
        logic load_out;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* src/bfws_ctrl.sv */
// Controller of the FIFO: sequences one request and owns the output valid flag.
// Depends on bfws_pkg for the command struct.
`default_nettype none

module bfws_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output bfws_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load_ok;

    // The output register may be refilled when empty or drained this cycle.
    assign load_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.do_op = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                if (load_ok) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* src/bfws_dp.sv */
// Datapath of the FIFO: entry memory, pointers, fill count, statistics, result register.
// Depends on bfws_pkg and on the assertion macro header.
`default_nettype none
`include "bounded_fifo_with_stats_top_macros.svh"

module bfws_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bfws_pkg::t_dp_cmd              i_cmd,
    input  wire bfws_pkg::t_in_req              i_in_req,
    input  wire logic [bfws_pkg::CFG_W-1:0]     i_max_entries,
    output bfws_pkg::t_out_rsp                  o_out_rsp
);

    localparam int AW = bfws_pkg::ADDR_W;
    localparam int CW = bfws_pkg::CNT_W;
    localparam int SW = bfws_pkg::STAT_W;
    localparam int WB = bfws_pkg::WORD_BITS;

    logic [WB-1:0] mem [bfws_pkg::DEPTH];

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_held, n_held;
    logic [SW-1:0] r_add_tries, n_add_tries;
    logic [SW-1:0] r_get_tries, n_get_tries;
    logic [SW-1:0] r_adds_done, n_adds_done;
    logic [SW-1:0] r_gets_done, n_gets_done;

    logic          r_ok;
    logic          r_kind;
    logic [WB-1:0] r_rd_data;
    bfws_pkg::t_out_rsp r_rsp;

    logic [CW-1:0] limit;
    logic          can_add;
    logic          can_get;
    logic          is_add;
    logic          ok;
    logic [WB-1:0] wr_word;

    function automatic logic [SW-1:0] sat_inc(input logic [SW-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        return (p == AW'(bfws_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        // A limit above the capacity acts as the capacity.
        if (CW'(i_max_entries) > CW'(bfws_pkg::DEPTH)) begin
            limit = CW'(bfws_pkg::DEPTH);
        end else begin
            limit = CW'(i_max_entries);
        end
        can_add = r_held < limit;
        can_get = r_held != '0;
        is_add  = i_in_req.kind == bfws_pkg::KIND_ADD;
        ok      = is_add ? can_add : can_get;
        wr_word = WB'(signed'(i_in_req.value));

        n_head      = r_head;
        n_tail      = r_tail;
        n_held      = r_held;
        n_add_tries = r_add_tries;
        n_get_tries = r_get_tries;
        n_adds_done = r_adds_done;
        n_gets_done = r_gets_done;
        if (i_cmd.do_op) begin
            if (is_add) begin
                n_add_tries = sat_inc(r_add_tries);
                if (can_add) begin
                    n_tail      = next_slot(r_tail);
                    n_held      = r_held + 1'b1;
                    n_adds_done = sat_inc(r_adds_done);
                end
            end else begin
                n_get_tries = sat_inc(r_get_tries);
                if (can_get) begin
                    n_head      = next_slot(r_head);
                    n_held      = r_held - 1'b1;
                    n_gets_done = sat_inc(r_gets_done);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_add_tries <= '0;
            r_get_tries <= '0;
            r_adds_done <= '0;
            r_gets_done <= '0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_held      <= n_held;
            r_add_tries <= n_add_tries;
            r_get_tries <= n_get_tries;
            r_adds_done <= n_adds_done;
            r_gets_done <= n_gets_done;
        end
    end

    // Entry memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_op && is_add && can_add) begin
            mem[r_tail] <= wr_word;
        end
        if (i_cmd.do_op && !is_add) begin
            r_rd_data <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_op) begin
            r_ok   <= ok;
            r_kind <= i_in_req.kind;
        end
    end

    // The counters and fill level are stable until the next request is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_rsp.accepted   <= r_ok;
            r_rsp.read_word  <= (r_ok && r_kind == bfws_pkg::KIND_GET) ?
                                32'(r_rd_data) : '0;
            r_rsp.fill_level <= 11'(r_held);
            r_rsp.add_tries  <= r_add_tries;
            r_rsp.get_tries  <= r_get_tries;
            r_rsp.adds_done  <= r_adds_done;
            r_rsp.gets_done  <= r_gets_done;
        end
    end

    assign o_out_rsp = r_rsp;

    `BFWS_ASSERT_NOW(a_held_bounded, i_clk, i_rst_n, 1'b1, r_held <= CW'(bfws_pkg::DEPTH), "fill count exceeds capacity")
    `BFWS_ASSERT_NOW(a_done_le_tries, i_clk, i_rst_n, 1'b1, (r_adds_done <= r_add_tries) && (r_gets_done <= r_get_tries), "done count above attempt count")
    `BFWS_ASSERT_NEXT(a_add_grows, i_clk, i_rst_n, i_cmd.do_op && is_add && can_add, r_held == $past(r_held) + 1'b1, "accepted add did not raise fill count")

endmodule

`default_nettype wire

/* src/bounded_fifo_with_stats_top.sv */
// A request is taken in the issue state; its result is loaded into the output register in
// the load state, and a full output register stalls the load. No new request is taken until
// the last one is loaded, set by the registered memory read and the issue/load sequence.
// Reset: synchronous active-low reset clears pointers, fill count, counters and the valid flag;
// the entry memory is not cleared, and there is no clearing pass.
// Depends on bfws_pkg, bfws_ctrl and bfws_dp.
`default_nettype none

module bounded_fifo_with_stats_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire bfws_pkg::t_in_req               i_in_req,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output bfws_pkg::t_out_rsp                   o_out_rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            paddr,
    input  wire logic [bfws_pkg::PDATA_W-1:0]    pwdata,
    output logic [bfws_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    logic [bfws_pkg::CFG_W-1:0] r_max_entries;
    bfws_pkg::t_dp_cmd          cmd;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= bfws_pkg::MAX_ENTRIES_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == bfws_pkg::REG_MAX_ENTRIES) begin
            r_max_entries <= pwdata[bfws_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == bfws_pkg::REG_MAX_ENTRIES) begin
            prdata = bfws_pkg::PDATA_W'(r_max_entries);
        end
    end

    bfws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    bfws_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_req      (i_in_req),
        .i_max_entries (r_max_entries),
        .o_out_rsp     (o_out_rsp)
    );

endmodule

`default_nettype wire
